### rtl/core/bnms_pkg.sv
// Package for the box non-maximum suppression core: sizes, types, state codes.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package bnms_pkg;
  localparam int MaxBoxes  = 64;
  localparam int CoordBits = 12;
  localparam int IdxBits   = $clog2(MaxBoxes);
  localparam int CntBits   = $clog2(MaxBoxes + 1);
  localparam int ThrBits   = 17;
  localparam logic [ThrBits-1:0] ThrReset = 17'd22938;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [CoordBits:0]   edge_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t w;
    coord_t h;
  } box_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t w;
    coord_t h;
    logic   last;
  } box_beat_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t w;
    coord_t h;
    logic   last;
    logic   ovf;
  } kept_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic             store_wr;   // write input beat at count
    logic             clear_set;  // clear count, marks, overflow
    logic             rd_en;      // registered store read
    logic [IdxBits-1:0] rd_addr;
    logic             ld_key;     // latch read box as sort key / anchor
    logic             ld_cmp;     // latch read box as compare operand
    logic             ord_wr;     // write order[ord_addr] <= ord_data
    logic [IdxBits-1:0] ord_addr;
    logic [IdxBits-1:0] ord_data;
    logic             ord_rd;     // registered order read
    logic [IdxBits-1:0] ord_rd_addr;
    logic             mult_go;    // register products of anchor vs operand
    logic             sup_check;  // compare products, maybe mark
    logic [IdxBits-1:0] mark_idx;
    logic             mark_rd;    // sample mark of mark_idx
  } nms_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CntBits-1:0] count;
    logic               key_gt;   // bottom(read box) > bottom(key)
    logic               marked;   // sampled mark
    logic [IdxBits-1:0] ord_q;
  } nms_stat_t;

  typedef enum logic [11:0] {
    S_LOAD    = 12'b000000000001,
    S_SRD     = 12'b000000000010,  // read key box i
    S_SKEY    = 12'b000000000100,
    S_SORD    = 12'b000000001000,  // read order[k-1]
    S_SBOX    = 12'b000000010000,  // read box order[k-1]
    S_SCMP    = 12'b000000100000,
    S_EORD    = 12'b000001000000,  // read order[p-1]
    S_EBOX    = 12'b000010000000,  // read anchor box and mark
    S_EOUT    = 12'b000100000000,  // present result
    S_CORD    = 12'b001000000000,  // read order[k]
    S_CBOX    = 12'b010000000000,  // read box order[k]
    S_CMUL    = 12'b100000000000   // latch operand, multiply, then compare
  } nms_state_t;
endpackage
`default_nettype wire

### rtl/core/bnms_if.sv
// Valid/ready stream interface carrying one payload beat.
// Depends on bnms_pkg only through the payload type parameter.
`timescale 1ns / 1ps
`default_nettype none
interface bnms_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/bnms_datapath.sv
// Datapath: box store, order table, removed marks, overlap arithmetic.
// Depends on bnms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bnms_datapath
  import bnms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire nms_cmd_t    cmd,
  input  wire box_beat_t   in_box,
  input  wire logic        in_drop,
  input  wire logic [ThrBits-1:0] thr,
  output nms_stat_t        stat,
  output box_t             anchor,
  output logic             ovf
);
  box_t              store [MaxBoxes];
  logic [IdxBits-1:0] order [MaxBoxes];
  logic [MaxBoxes-1:0] marks;
  logic [CntBits-1:0] count;
  box_t rd_q, key, cmp;
  logic [IdxBits-1:0] ord_q;
  logic [IdxBits-1:0] cmp_idx, cmp_idx_q;
  logic [2*CoordBits+1:0] inter;
  logic [2*CoordBits-1:0] area;
  logic mark_q;

  always_ff @(posedge clk) begin
    if (cmd.store_wr) store[count[IdxBits-1:0]] <= {in_box.l, in_box.t, in_box.w, in_box.h};
    if (cmd.rd_en) rd_q <= store[cmd.rd_addr];
    if (cmd.ord_wr) order[cmd.ord_addr] <= cmd.ord_data;
    if (cmd.ord_rd) ord_q <= order[cmd.ord_rd_addr];
  end

  // intersection of anchor (key) with operand (cmp)
  edge_t lmax, tmax, rmin, bmin, ra, rb, ba, bb;
  logic [CoordBits:0] iw, ih;
  always_comb begin
    ra = {1'b0, key.l} + {1'b0, key.w};
    rb = {1'b0, cmp.l} + {1'b0, cmp.w};
    ba = {1'b0, key.t} + {1'b0, key.h};
    bb = {1'b0, cmp.t} + {1'b0, cmp.h};
    lmax = (key.l > cmp.l) ? {1'b0, key.l} : {1'b0, cmp.l};
    tmax = (key.t > cmp.t) ? {1'b0, key.t} : {1'b0, cmp.t};
    rmin = (ra < rb) ? ra : rb;
    bmin = (ba < bb) ? ba : bb;
    iw = (rmin > lmax) ? rmin - lmax : '0;
    ih = (bmin > tmax) ? bmin - tmax : '0;
  end

  logic [2*CoordBits+ThrBits+1:0] lhs, rhs;
  assign lhs = {1'b0, inter, 16'd0};
  assign rhs = (2*CoordBits+ThrBits+2)'(thr) * (2*CoordBits+ThrBits+2)'(area);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      marks <= '0;
      ovf <= 1'b0;
    end else begin
      if (cmd.clear_set) begin
        count <= '0;
        marks <= '0;
        ovf <= 1'b0;
      end else begin
        if (cmd.store_wr) count <= count + 1'b1;
        if (in_drop) ovf <= 1'b1;
        if (cmd.sup_check && (lhs > rhs)) marks[cmp_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_key) key <= rd_q;
    if (cmd.ld_cmp) begin
      cmp <= rd_q;
      cmp_idx_q <= cmp_idx;
    end
    if (cmd.rd_en) cmp_idx <= cmd.rd_addr;
    if (cmd.mult_go) begin
      inter <= iw * ih;
      area <= cmp.w * cmp.h;
    end
    if (cmd.mark_rd) mark_q <= marks[cmd.mark_idx];
  end

  assign anchor = key;
  assign stat.count = count;
  assign stat.key_gt = ({1'b0, rd_q.t} + {1'b0, rd_q.h}) > ({1'b0, key.t} + {1'b0, key.h});
  assign stat.marked = mark_q;
  assign stat.ord_q = ord_q;
endmodule
`default_nettype wire

### rtl/core/bnms_ctrl.sv
// Controller: load, insertion sort over the order table, emit and suppress.
// Depends on bnms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bnms_ctrl
  import bnms_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_last,
  output logic           in_ready,
  output logic           in_drop,
  input  wire logic      out_ready,
  output logic           out_valid,
  output logic           out_last,
  output nms_cmd_t       cmd,
  input  wire nms_stat_t stat
);
  nms_state_t state, state_next;
  logic [CntBits-1:0] i, i_next, k, k_next, n, n_next, p, p_next;
  logic [IdxBits-1:0] hold, hold_next;   // order[k-1] value being shifted
  logic any_kept, any_kept_next;
  logic valid_r, valid_next;
  logic [CntBits-1:0] nxt_alive_p; // order position of the next candidate

  assign nxt_alive_p = p - 1'b1;
  assign in_ready = (state == S_LOAD);
  // pending result is offered only once its last flag is known
  assign out_valid = valid_r && ((state == S_EOUT && !stat.marked) ||
                                 (state == S_EORD && p == '0));
  assign in_drop = in_ready && in_valid && (stat.count == CntBits'(MaxBoxes));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      valid_r <= 1'b0;
      any_kept <= 1'b0;
    end else begin
      state <= state_next;
      valid_r <= valid_next;
      any_kept <= any_kept_next;
    end
    i <= i_next; k <= k_next; n <= n_next; p <= p_next; hold <= hold_next;
  end

  // last kept: no remaining unmarked box in order below p; computed lazily:
  // result is held until next anchor found or scan ends, so last flag known then.
  always_comb begin
    state_next = state;
    i_next = i; k_next = k; n_next = n; p_next = p; hold_next = hold;
    valid_next = valid_r;
    any_kept_next = any_kept;
    out_last = 1'b0;
    cmd = '0;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.store_wr = (stat.count != CntBits'(MaxBoxes));
          if (in_last) begin
            n_next = (stat.count != CntBits'(MaxBoxes)) ? stat.count + 1'b1 : stat.count;
            i_next = '0;
            state_next = S_SRD;
          end
        end
      end
      S_SRD: begin
        if (i == n) begin
          p_next = n;
          any_kept_next = 1'b0;
          state_next = S_EORD;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_addr = i[IdxBits-1:0];
          k_next = i;
          state_next = S_SKEY;
        end
      end
      S_SKEY: begin
        cmd.ld_key = 1'b1;
        state_next = S_SORD;
      end
      S_SORD: begin
        if (k == '0) begin
          cmd.ord_wr = 1'b1;
          cmd.ord_addr = '0;
          cmd.ord_data = i[IdxBits-1:0];
          i_next = i + 1'b1;
          state_next = S_SRD;
        end else begin
          cmd.ord_rd = 1'b1;
          cmd.ord_rd_addr = IdxBits'(k - 1'b1);
          state_next = S_SBOX;
        end
      end
      S_SBOX: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = stat.ord_q;
        hold_next = stat.ord_q;
        state_next = S_SCMP;
      end
      S_SCMP: begin
        cmd.ord_wr = 1'b1;
        cmd.ord_addr = k[IdxBits-1:0];
        if (stat.key_gt) begin
          cmd.ord_data = hold;
          k_next = k - 1'b1;
          state_next = S_SORD;
        end else begin
          cmd.ord_data = i[IdxBits-1:0];
          i_next = i + 1'b1;
          state_next = S_SRD;
        end
      end
      S_EORD: begin
        if (p == '0) begin
          if (valid_r) begin
            out_last = 1'b1;
            if (out_ready) begin
              valid_next = 1'b0;
              cmd.clear_set = 1'b1;
              state_next = S_LOAD;
            end
          end else begin
            cmd.clear_set = 1'b1;
            state_next = S_LOAD;
          end
        end else begin
          cmd.ord_rd = 1'b1;
          cmd.ord_rd_addr = IdxBits'(nxt_alive_p);
          state_next = S_EBOX;
        end
      end
      S_EBOX: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = stat.ord_q;
        cmd.mark_rd = 1'b1;
        cmd.mark_idx = stat.ord_q;
        p_next = p - 1'b1;
        state_next = S_EOUT;
      end
      S_EOUT: begin
        // previous result still pending: it is not last, release it first
        if (stat.marked) begin
          state_next = S_EORD;
        end else if (!valid_r || out_ready) begin
          cmd.ld_key = 1'b1;
          valid_next = 1'b1;
          k_next = '0;
          state_next = S_CORD;
        end
      end
      S_CORD: begin
        if (k == p) begin
          state_next = S_EORD;
        end else begin
          cmd.ord_rd = 1'b1;
          cmd.ord_rd_addr = k[IdxBits-1:0];
          state_next = S_CBOX;
        end
      end
      S_CBOX: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = stat.ord_q;
        state_next = S_CMUL;
        hold_next = '0;
      end
      S_CMUL: begin
        // first pass: latch operand; hold tracks phase
        if (hold == '0) begin
          cmd.ld_cmp = 1'b1;
          hold_next = IdxBits'(1);
        end else if (hold == IdxBits'(1)) begin
          cmd.mult_go = 1'b1;
          hold_next = IdxBits'(2);
        end else begin
          cmd.sup_check = 1'b1;
          k_next = k + 1'b1;
          state_next = S_CORD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/box_non_maximum_suppression_core.sv
// Top level of the greedy box non-maximum suppression core.
// Depends on bnms_pkg, bnms_if, bnms_ctrl, bnms_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Boxes load one per beat, up to 64 per set; extras are dropped and flagged
// on every result. The last beat starts an insertion sort by bottom edge
// and then greedy suppression: each kept box is compared with every
// lower-ordered box, one pair at a time, through the registered store and
// order reads and the staged multiply. Each result is held, and its valid
// raised, only once the next kept box is found or the scan ends, so that
// kept_last is exact.
module box_non_maximum_suppression_core
  import bnms_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [ThrBits-1:0] cfg_wdata,
  bnms_if.sink   in_ch,
  bnms_if.source out_ch
);
  logic [ThrBits-1:0] thr;
  nms_cmd_t  cmd;
  nms_stat_t stat;
  box_t      anchor;
  logic      ovf, in_drop, out_valid, out_last;

  always_ff @(posedge clk) begin
    if (rst) thr <= ThrReset;
    else if (cfg_we) thr <= cfg_wdata;
  end

  bnms_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_last  (in_ch.data.last),
    .in_ready (in_ch.ready),
    .in_drop,
    .out_ready(out_ch.ready),
    .out_valid,
    .out_last,
    .cmd, .stat
  );

  bnms_datapath u_dp (
    .clk, .rst, .cmd,
    .in_box (in_ch.data),
    .in_drop, .thr, .stat, .anchor, .ovf
  );

  assign out_ch.valid = out_valid;
  assign out_ch.data = '{l: anchor.l, t: anchor.t, w: anchor.w, h: anchor.h,
                         last: out_last, ovf: ovf};
endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for box_non_maximum_suppression_core: loads box sets,
// predicts the kept boxes in-bench and checks every output beat in order.
// Depends on bnms_pkg, bnms_if and the core RTL.
`timescale 1ns / 1ps
module tb_top;
  import bnms_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ThrBits-1:0] cfg_wdata = '0;

  bnms_if #(.payload_t(box_beat_t))  in_if  (clk);
  bnms_if #(.payload_t(kept_beat_t)) out_if (clk);

  box_non_maximum_suppression_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  always #5 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    out_if.ready = 1'b0;
  end

  // predictor state
  logic [ThrBits-1:0] thr_model = ThrReset;
  box_t       set_boxes[$];
  bit         set_ovf = 0;
  kept_beat_t kept_q[$];
  int         errors = 0;

  // stimulus knobs
  bit idle_on = 1;
  bit hold_req = 0;
  int clu_x, clu_y;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit box_suppresses(input box_t a, input box_t b,
                                        input logic [ThrBits-1:0] thr);
    edge_t lmax, tmax, ra, rb, ba, bb, rmin, bmin;
    longint unsigned iw, ih, inter, area;
    lmax = (a.l > b.l) ? edge_t'(a.l) : edge_t'(b.l);
    tmax = (a.t > b.t) ? edge_t'(a.t) : edge_t'(b.t);
    ra = edge_t'(a.l) + edge_t'(a.w);  rb = edge_t'(b.l) + edge_t'(b.w);
    ba = edge_t'(a.t) + edge_t'(a.h);  bb = edge_t'(b.t) + edge_t'(b.h);
    rmin = (ra < rb) ? ra : rb;
    bmin = (ba < bb) ? ba : bb;
    iw = (rmin > lmax) ? longint'(rmin - lmax) : 0;
    ih = (bmin > tmax) ? longint'(bmin - tmax) : 0;
    inter = iw * ih;
    area = longint'(b.w) * longint'(b.h);
    return (inter * 65536) > (longint'(thr) * area);
  endfunction

  function automatic edge_t bottom(input box_t b);
    return edge_t'(b.t) + edge_t'(b.h);
  endfunction

  // greedy suppression of the collected set, results appended to kept_q
  task automatic predict_kept();
    int ord[$];
    bit gone[$];
    int n, i, k, p, last_pos;
    kept_beat_t kb;
    n = set_boxes.size();
    for (i = 0; i < n; i++) begin
      // stable insertion by bottom edge
      k = ord.size();
      while (k > 0 && bottom(set_boxes[ord[k-1]]) > bottom(set_boxes[i])) k--;
      ord.insert(k, i);
      gone = {gone, 1'b0};
    end
    last_pos = -1;
    for (p = n - 1; p >= 0; p--) begin
      if (!gone[ord[p]]) begin
        kb.l = set_boxes[ord[p]].l;
        kb.t = set_boxes[ord[p]].t;
        kb.w = set_boxes[ord[p]].w;
        kb.h = set_boxes[ord[p]].h;
        kb.last = 1'b0;
        kb.ovf = set_ovf;
        kept_q = {kept_q, kb};
        last_pos = kept_q.size() - 1;
        for (k = 0; k < p; k++)
          if (!gone[ord[k]] && box_suppresses(set_boxes[ord[p]], set_boxes[ord[k]], thr_model))
            gone[ord[k]] = 1;
      end
    end
    if (last_pos >= 0) kept_q[last_pos].last = 1'b1;
    set_boxes.delete();
    set_ovf = 0;
  endtask

  // one input beat; returns after the beat has been taken, valid left high
  // unless an idle burst follows
  task automatic send_box(input coord_t l, input coord_t t, input coord_t w,
                          input coord_t h, input bit last);
    box_beat_t bb;
    box_t b;
    bit done;
    bb.l = l; bb.t = t; bb.w = w; bb.h = h; bb.last = last;
    in_if.data  <= bb;
    in_if.valid <= 1'b1;
    done = 0;
    while (!done) begin
      @(negedge clk);
      done = in_if.ready;
      @(posedge clk);
    end
    b.l = l; b.t = t; b.w = w; b.h = h;
    if (set_boxes.size() < MaxBoxes) set_boxes = {set_boxes, b};
    else set_ovf = 1;
    if (last) predict_kept();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_rand_box(input bit last, input bit clustered);
    coord_t l, t, w, h;
    if (clustered) begin
      l = coord_t'(clu_x + $urandom_range(0, 40));
      t = coord_t'(clu_y + $urandom_range(0, 40));
      w = coord_t'($urandom_range(0, 80));
      h = coord_t'($urandom_range(0, 80));
    end else begin
      l = coord_t'($urandom); t = coord_t'($urandom);
      w = coord_t'($urandom); h = coord_t'($urandom);
    end
    send_box(l, t, w, h, last);
  endtask

  task automatic send_rand_set(input int n);
    int i;
    bit cl;
    cl = ($urandom_range(0, 4) != 0);
    clu_x = $urandom_range(0, 4000);
    clu_y = $urandom_range(0, 4000);
    for (i = 0; i < n; i++) send_rand_box(i == n - 1, cl);
  endtask

  // pause until all kept boxes are out, then let the core settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [ThrBits-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_model = v;
  endtask

  task automatic test_directed();
    send_box(0, 0, 0, 0, 1);
    send_box(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1);
    // identical pair: later one kept, earlier suppressed
    send_box(100, 100, 50, 50, 0);
    send_box(100, 100, 50, 50, 1);
    // equal bottoms, disjoint: later arrival first
    send_box(10, 20, 5, 30, 0);
    send_box(500, 40, 5, 10, 1);
    // zero-area box inside a big one survives
    send_box(200, 200, 0, 10, 0);
    send_box(190, 190, 100, 100, 1);
    // partial overlaps around the reset threshold
    send_box(0, 0, 100, 100, 0);
    send_box(60, 0, 100, 100, 0);
    send_box(70, 10, 100, 100, 0);
    send_box(3000, 3000, 1, 1, 1);
    drain();
  endtask

  task automatic test_threshold();
    write_threshold(17'd0);
    send_box(0, 0, 10, 10, 0);
    send_box(9, 9, 10, 10, 0);
    send_box(5, 5, 1, 1, 1);
    write_threshold(17'd65536);
    send_box(0, 0, 10, 10, 0);
    send_box(0, 0, 10, 10, 1);
    write_threshold(17'h1FFFF);
    repeat (4) send_rand_set($urandom_range(2, 6));
    write_threshold(17'h0AAAA);
    repeat (4) send_rand_set($urandom_range(2, 6));
    write_threshold(17'h15555);
    repeat (4) send_rand_set($urandom_range(2, 6));
    write_threshold(ThrReset);
  endtask

  task automatic test_overflow();
    send_rand_set(MaxBoxes);
    send_rand_set(MaxBoxes + 3);
    drain();
  endtask

  task automatic test_stall();
    send_rand_set(4);
    hold_req = 1;
    repeat (6) send_rand_set($urandom_range(1, 5));
    drain();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 240) begin
      int n;
      n = ($urandom_range(0, 30) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      send_rand_set(n);
      sent += n;
      if ($urandom_range(0, 40) == 0) write_threshold(ThrBits'($urandom_range(0, 65536)));
    end
    write_threshold(ThrReset);
    idle_on = 0;
    repeat (8) send_rand_set($urandom_range(1, 6));
  endtask

  // result side: random gaps and one long hold-off
  int gap_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (gap_left > 0) begin
      out_if.ready <= 1'b0;
      gap_left--;
    end else begin
      out_if.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 5);
    end
  end

  always @(negedge clk) begin
    kept_beat_t got, want;
    if (!rst && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (kept_q.size() == 0) begin
        report_mismatch("unexpected beat", got.l, -1);
      end else begin
        want = kept_q.pop_front();
        if (got.l != want.l) report_mismatch("kept_left", got.l, want.l);
        if (got.t != want.t) report_mismatch("kept_top", got.t, want.t);
        if (got.w != want.w) report_mismatch("kept_width", got.w, want.w);
        if (got.h != want.h) report_mismatch("kept_height", got.h, want.h);
        if (got.last != want.last) report_mismatch("kept_last", got.last, want.last);
        if (got.ovf != want.ovf) report_mismatch("overflow", got.ovf, want.ovf);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_threshold();
    test_overflow();
    test_stall();
    test_random();
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
